// ===== hw/rtl/kdplr_pkg.sv =====
// Shared types and constants for the key debounce unit.
package kdplr_pkg;

    localparam int KEY_W  = 2;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 1;

    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG    = 2'd2;

    localparam logic [ADDR_W-1:0] REG_FILTER_TIME = 1'd0;
    localparam logic [ADDR_W-1:0] REG_LONG_TIME   = 1'd1;

    localparam logic [31:0] FILTER_TIME_RST = 32'd5;
    localparam logic [31:0] LONG_TIME_RST   = 32'd100;

    typedef struct packed {
        logic              fire;
        logic [KIND_W-1:0] kind;
    } lane_ev_t;

endpackage

// ===== hw/rtl/key_debounce_press_release_long_unit.sv =====
// Top level: four-key debouncer with press, release and long-press events.
//
//  channel   dir  fields                                    transfer when
//  s_axis    in   tdata: key_down                           tvalid & tready
//  m_axis    out  tdata: key_index; tuser: event_kind;      tvalid & tready
//                 tlast: last_event
//  cfg       in   idx 0 filter_time, idx 1 long_time       cfg_we
//
// A tick is taken on each s_axis transfer; all key lanes update together in that cycle.
// Its events leave one per cycle from the merge stage while m_axis_tready
// is high, at most NUM_KEYS events per tick.
// One tick waits in a holding register while the previous one drains, so
// a stall on m_axis blocks s_axis only once that register is full.
// Reset clears all key state and loads filter_time 5, long_time 100.
module key_debounce_press_release_long_unit #(
    parameter int NUM_KEYS    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((NUM_KEYS + 7) / 8) * 8 - 1:0]  s_axis_tdata,  // key_down
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [7:0]                              m_axis_tdata,  // key_index
    output logic [kdplr_pkg::KIND_W-1:0]            m_axis_tuser,  // event_kind
    output logic                                    m_axis_tlast,
    input  logic                                    cfg_we,
    input  logic [kdplr_pkg::ADDR_W-1:0]            cfg_addr,
    input  logic [kdplr_pkg::CFG_W-1:0]             cfg_wdata
);

    logic [COUNT_WIDTH-1:0]                  filter_time_reg;
    logic [COUNT_WIDTH-1:0]                  long_time_reg;
    logic [31:0]                             cfg_ext;
    logic                                    in_xfer;
    kdplr_pkg::lane_ev_t [NUM_KEYS-1:0]      lane_ev;
    logic [kdplr_pkg::KEY_W-1:0]             key_index;

    assign cfg_ext = {{(32 - kdplr_pkg::CFG_W){1'b0}}, cfg_wdata};
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg <= kdplr_pkg::FILTER_TIME_RST[COUNT_WIDTH-1:0];
            long_time_reg   <= kdplr_pkg::LONG_TIME_RST[COUNT_WIDTH-1:0];
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                kdplr_pkg::REG_FILTER_TIME: filter_time_reg <= cfg_ext[COUNT_WIDTH-1:0];
                kdplr_pkg::REG_LONG_TIME:   long_time_reg   <= cfg_ext[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kdplr_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (in_xfer),
            .down        (s_axis_tdata[k]),
            .filter_time (filter_time_reg),
            .long_time   (long_time_reg),
            .ev          (lane_ev[k])
        );
    end

    kdplr_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_xfer),
        .ev         (lane_ev),
        .ready      (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .key_index  (key_index),
        .event_kind (m_axis_tuser),
        .last_event (m_axis_tlast)
    );

    assign m_axis_tdata = {{(8 - kdplr_pkg::KEY_W){1'b0}}, key_index};

    a_tdata_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:kdplr_pkg::KEY_W] == '0 &&
            (m_axis_tuser == kdplr_pkg::EV_PRESS || m_axis_tuser == kdplr_pkg::EV_RELEASE ||
             m_axis_tuser == kdplr_pkg::EV_LONG))
        else $error("malformed event on output");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_addr == kdplr_pkg::REG_LONG_TIME |=> $stable(filter_time_reg))
        else $error("long_time write disturbed filter_time");

    a_no_cfg_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(filter_time_reg) && $stable(long_time_reg))
        else $error("configuration changed without a write");

endmodule

// ===== hw/rtl/kdplr_lane.sv =====
// One key: up/down filter counter, pressed flag and hold counter.
module kdplr_lane #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    down,
    input  logic [COUNT_WIDTH-1:0]  filter_time,
    input  logic [COUNT_WIDTH-1:0]  long_time,
    output kdplr_pkg::lane_ev_t     ev
);

    logic [COUNT_WIDTH-1:0] filter_reg;
    logic [COUNT_WIDTH-1:0] filter_next;
    logic                   pressed_reg;
    logic                   pressed_next;
    logic [COUNT_WIDTH:0]   hold_reg;
    logic [COUNT_WIDTH:0]   hold_next;
    logic [COUNT_WIDTH:0]   long_ext;
    logic [COUNT_WIDTH:0]   long_plus;

    assign long_ext  = {1'b0, long_time};
    assign long_plus = long_ext + (COUNT_WIDTH + 1)'(1);

    always_comb
    begin
        filter_next  = filter_reg;
        pressed_next = pressed_reg;
        hold_next    = hold_reg;
        ev.fire      = 1'b0;
        ev.kind      = kdplr_pkg::EV_PRESS;
        if (down)
        begin
            if (filter_reg < filter_time)
            begin
                filter_next = filter_reg + COUNT_WIDTH'(1);
            end
            else if (!pressed_reg)
            begin
                pressed_next = 1'b1;
                ev.fire      = 1'b1;
                ev.kind      = kdplr_pkg::EV_PRESS;
            end
            else
            begin
                if (hold_reg == long_ext)
                begin
                    ev.fire = 1'b1;
                    ev.kind = kdplr_pkg::EV_LONG;
                end
                // saturate one past the long time so the event fires once per hold
                if (hold_reg < long_plus)
                begin
                    hold_next = hold_reg + (COUNT_WIDTH + 1)'(1);
                end
            end
        end
        else
        begin
            if (filter_reg != '0)
            begin
                filter_next = filter_reg - COUNT_WIDTH'(1);
            end
            else
            begin
                if (pressed_reg)
                begin
                    ev.fire = 1'b1;
                    ev.kind = kdplr_pkg::EV_RELEASE;
                end
                pressed_next = 1'b0;
                hold_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg  <= '0;
            pressed_reg <= 1'b0;
            hold_reg    <= '0;
        end
        else if (step)
        begin
            filter_reg  <= filter_next;
            pressed_reg <= pressed_next;
            hold_reg    <= hold_next;
        end
    end

    // hold only runs while the key is pressed
    a_hold_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        !pressed_reg |-> hold_reg == '0)
        else $error("hold count running on a released key");

    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(filter_reg) && $stable(hold_reg) && $stable(pressed_reg))
        else $error("lane state moved without a tick");

    a_press_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev.fire && ev.kind == kdplr_pkg::EV_PRESS |=> pressed_reg)
        else $error("press event without pressed flag");

endmodule

// ===== hw/rtl/kdplr_merge.sv =====
// Event merge: holds one tick's lane events and sends them in key order.
module kdplr_merge #(
    parameter int NUM_KEYS = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  kdplr_pkg::lane_ev_t [NUM_KEYS-1:0]     ev,
    output logic                                   ready,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [kdplr_pkg::KEY_W-1:0]            key_index,
    output logic [kdplr_pkg::KIND_W-1:0]           event_kind,
    output logic                                   last_event
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic                                        pend_valid_reg;
    logic                                        pend_valid_next;
    logic [NUM_KEYS-1:0]                         pend_mask_reg;
    logic [NUM_KEYS-1:0][kdplr_pkg::KIND_W-1:0]  pend_kind_reg;
    logic [NUM_KEYS-1:0]                         emit_mask_reg;
    logic [NUM_KEYS-1:0]                         emit_mask_next;
    logic [NUM_KEYS-1:0][kdplr_pkg::KIND_W-1:0]  emit_kind_reg;
    logic [NUM_KEYS-1:0]                         in_mask;
    logic [NUM_KEYS-1:0]                         rest_mask;
    logic [4:0]                                  sel;
    logic                                        out_xfer;
    logic                                        emit_free;
    logic                                        take;

    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            in_mask[i] = ev[i].fire;
        end
    end

    // lowest pending key goes first
    always_comb
    begin
        sel = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (emit_mask_reg[i])
            begin
                sel = 5'(i);
            end
        end
    end

    assign rest_mask  = emit_mask_reg & (emit_mask_reg - NUM_KEYS'(1));
    assign out_valid  = |emit_mask_reg;
    assign last_event = (rest_mask == '0);
    assign key_index  = sel[1:0];
    assign event_kind = emit_kind_reg[sel[IDX_W-1:0]];
    assign out_xfer   = out_valid && out_ready;
    assign emit_free  = !out_valid || (out_xfer && last_event);
    assign ready      = !pend_valid_reg || emit_free;
    assign take       = load && (in_mask != '0);

    always_comb
    begin
        emit_mask_next  = emit_mask_reg;
        pend_valid_next = pend_valid_reg;
        if (emit_free)
        begin
            emit_mask_next  = pend_valid_reg ? pend_mask_reg : '0;
            pend_valid_next = 1'b0;
        end
        else if (out_xfer)
        begin
            emit_mask_next = rest_mask;
        end
        if (take)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            emit_mask_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            emit_mask_reg  <= emit_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_free && pend_valid_reg)
        begin
            emit_kind_reg <= pend_kind_reg;
        end
        if (take)
        begin
            pend_mask_reg <= in_mask;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                pend_kind_reg[i] <= ev[i].kind;
            end
        end
    end

    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> pend_valid_reg)
        else $error("tick with events was not held");

    a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !emit_free |=> pend_valid_reg && $stable(pend_mask_reg))
        else $error("waiting events lost");

    a_one_per_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last_event |=>
            $countones(emit_mask_reg) == $countones($past(emit_mask_reg)) - 1)
        else $error("transfer did not retire exactly one event");

    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_mask_reg != '0)
        else $error("empty tick held");

endmodule
